FILE: hw/rtl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int DATA_W      = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int DIGIT_IDX_W = 4;
    localparam int STEP_W      = 5;
    localparam int CHAR_W      = 6;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DATA_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Classified item: sign flag and unsigned magnitude
    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] mag;
    } item_t;

endpackage

FILE: hw/rtl/sitda_front.sv
// Front end: accepts input transactions, splits sign and magnitude, feeds the queue.
`timescale 1ns / 1ps

module sitda_front import sitda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,
    output logic                  push,
    input  logic                  full,
    output item_t                 push_data
);

    logic  valid_reg;
    item_t item_reg;
    logic  accept;

    assign push          = valid_reg && !full;
    assign s_axis_tready = !valid_reg || !full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_data     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Two's complement negate; the most negative value maps onto itself as unsigned
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.neg <= s_axis_tdata[DATA_W-1];
            item_reg.mag <= s_axis_tdata[DATA_W-1] ? (DATA_W'(0) - s_axis_tdata[DATA_W-1:0])
                                                   : s_axis_tdata[DATA_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/sitda_queue.sv
// Short queue of classified items between front end and converter.
`timescale 1ns / 1ps

module sitda_queue import sitda_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output item_t pop_data,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/sitda_back.sv
// Back end: shift-add-3 binary to BCD conversion, then character emission.
`timescale 1ns / 1ps

module sitda_back import sitda_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   empty,
    output logic                   pop,
    input  item_t                  pop_data,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

    state_t                 state_reg;
    logic [DATA_W-1:0]      bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   sign_pend_reg;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic                   out_last_reg;

    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_step;
    logic [DIGIT_IDX_W-1:0] top_idx;
    logic [3:0]             cur_digit;
    logic                   load_ok;

    assign pop           = (state_reg == ST_IDLE) && !empty;
    assign load_ok       = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W-CHAR_W){1'b0}}, out_char_reg};
    assign m_axis_tlast  = out_last_reg;
    assign cur_digit     = bcd_reg[idx_reg*4 +: 4];

    // One double-dabble step: add 3 to each digit of 5 or more, then shift in a bit
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                            : bcd_reg[i*4 +: 4];
        end
        bcd_step = {bcd_adj[BCD_W-2:0], bin_reg[DATA_W-1]};
    end

    // Highest nonzero digit of the finished BCD word; zero keeps index 0
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_step[i*4 +: 4] != 4'd0)
            begin
                top_idx = DIGIT_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_reg       <= '0;
            bcd_reg       <= '0;
            step_reg      <= '0;
            sign_pend_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // While emitting, a taken character is always replaced by the next one
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        bin_reg       <= pop_data.mag;
                        sign_pend_reg <= pop_data.neg;
                        bcd_reg       <= '0;
                        step_reg      <= '0;
                        state_reg     <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    bcd_reg  <= bcd_step;
                    bin_reg  <= {bin_reg[DATA_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        idx_reg   <= top_idx;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (load_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        if (sign_pend_reg)
                        begin
                            out_char_reg  <= CHAR_MINUS;
                            out_last_reg  <= 1'b0;
                            sign_pend_reg <= 1'b0;
                        end
                        else
                        begin
                            out_char_reg <= CHAR_ZERO + {2'b00, cur_digit};
                            out_last_reg <= (idx_reg == '0);
                            if (idx_reg == '0)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg - 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//  Channel  | Dir | Signals                         | Contents
//  ---------+-----+---------------------------------+-------------------------------------
//  s_axis   | in  | tvalid, tready, tdata[31:0]     | value (signed, two's complement)
//  m_axis   | out | tvalid, tready, tdata[7:0], tlast| character [5:0], zero pad; tlast=last
//
// Each input transaction is taken from the queue, run through the shift-add-3 loop
// over all 32 magnitude bits, then emitted character by character ('-' plus 1..10
// digits) through the output register.
// The front register and a QUEUE_DEPTH-entry queue hold further inputs while
// the converter works, so s_axis stalls only once both are full.
// m_axis back-pressure holds the output register and pauses emission.
// rst_n is asynchronous and active low; it clears all handshake and sequencer state.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii import sitda_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input transaction
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [31:0] value
    // Output transaction, one character each
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic                   m_axis_tlast    // last character of the number
);

    // Front end to queue
    logic  q_push;
    logic  q_full;
    item_t q_push_data;

    // Queue to converter
    logic  q_pop;
    logic  q_empty;
    item_t q_pop_data;

    // Registers the input and forms sign and magnitude
    sitda_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (q_push),
        .full          (q_full),
        .push_data     (q_push_data)
    );

    // Decouples input acceptance from the long conversion
    sitda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // BCD conversion and character sequencer with output register
    sitda_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (q_empty),
        .pop           (q_pop),
        .pop_data      (q_pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
